// File: hdl/dsu_pkg.sv
// Shared types and constants for the disjoint-set union engine.
// No dependencies; imported by dsu_ctrl, the top level and the bench.
package dsu_pkg;

    localparam int NODES_DEF = 1024;
    localparam int NODE_W    = 10;
    localparam int SIZE_W    = 11;

    localparam logic OP_JOIN  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic              merged;
        logic [NODE_W-1:0] result_root;
        logic [SIZE_W-1:0] set_size;
        logic [SIZE_W-1:0] largest_size;
    } dsu_res_t;

endpackage

// File: hdl/dsu_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Holds the parent and size tables of the disjoint-set union engine.
module dsu_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/dsu_ctrl.sv
// Sequencer of the disjoint-set union engine: clearing sweep, index reduction,
// root walks with path halving, union by size. Drives both table RAMs.
// Depends on dsu_pkg.
module dsu_ctrl #(
    parameter int NODES = dsu_pkg::NODES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             opcode,
    input  logic [dsu_pkg::NODE_W-1:0]       node_a,
    input  logic [dsu_pkg::NODE_W-1:0]       node_b,
    output logic                             res_valid,
    input  logic                             res_ready,
    output dsu_pkg::dsu_res_t                res,
    output logic                             pa_we,
    output logic [$clog2(NODES)-1:0]         pa_waddr,
    output logic [$clog2(NODES)-1:0]         pa_wdata,
    output logic [$clog2(NODES)-1:0]         pa_raddr,
    input  logic [$clog2(NODES)-1:0]         pa_rdata,
    output logic                             sz_we,
    output logic [$clog2(NODES)-1:0]         sz_waddr,
    output logic [$clog2(NODES):0]           sz_wdata,
    output logic [$clog2(NODES)-1:0]         sz_raddr,
    input  logic [$clog2(NODES):0]           sz_rdata
);

    import dsu_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int SW = IW + 1;
    localparam int RW = (IW > NODE_W) ? IW : NODE_W;
    localparam bit NODES_POW2 = ((NODES & (NODES - 1)) == 0);
    localparam logic [RW:0]   NODES_W   = (RW + 1)'(NODES);
    localparam logic [RW-1:0] NODE_MASK = RW'(NODES - 1);
    localparam logic [IW-1:0] LAST_NODE = IW'(NODES - 1);

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_REDUCE, ST_RD_N, ST_CHK_P, ST_CHK_G, ST_WR,
        ST_SZ_A, ST_SZ_B, ST_MERGE, ST_RESULT
    } state_t;

    state_t        state_reg;
    logic [IW-1:0] cnt_reg;
    logic          clr_pend_reg;
    logic          phase_reg;
    logic [RW-1:0] a_reg;
    logic [RW-1:0] b_reg;
    logic [IW-1:0] cur_reg;
    logic [IW-1:0] nxt_reg;
    logic [IW-1:0] ra_reg;
    logic [IW-1:0] rb_reg;
    logic [SW-1:0] sa_reg;
    logic [SW-1:0] largest_reg;
    dsu_res_t      res_reg;

    logic [RW-1:0] a_load;
    logic [RW-1:0] b_load;
    logic          found;
    logic [IW-1:0] found_node;
    logic          distinct;
    logic [IW-1:0] top_node;
    logic [IW-1:0] low_node;
    logic [SW-1:0] sum_size;
    logic [SW-1:0] out_size;
    logic [SW-1:0] largest_next;
    logic [31:0]   root_w;
    logic [31:0]   size_w;
    logic [31:0]   largest_w;
    dsu_res_t      merge_res;

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

    assign a_load = NODES_POW2 ? (RW'(node_a) & NODE_MASK) : RW'(node_a);
    assign b_load = NODES_POW2 ? (RW'(node_b) & NODE_MASK) : RW'(node_b);

    always_comb begin
        found      = 1'b0;
        found_node = cur_reg;
        if (state_reg == ST_CHK_P && pa_rdata == cur_reg) begin
            found = 1'b1;
        end else if (state_reg == ST_CHK_G && pa_rdata == nxt_reg) begin
            found      = 1'b1;
            found_node = nxt_reg;
        end
    end

    always_comb begin
        distinct = (ra_reg != rb_reg);
        if (sa_reg > sz_rdata) begin
            top_node = ra_reg;
            low_node = rb_reg;
        end else begin
            top_node = rb_reg;
            low_node = ra_reg;
        end
        if (!distinct) begin
            top_node = ra_reg;
        end
        sum_size     = sa_reg + sz_rdata;
        out_size     = distinct ? sum_size : sa_reg;
        largest_next = (distinct && sum_size > largest_reg) ? sum_size : largest_reg;
        root_w       = 32'(top_node);
        size_w       = 32'(out_size);
        largest_w    = 32'(largest_next);
        merge_res.merged       = distinct;
        merge_res.result_root  = root_w[NODE_W-1:0];
        merge_res.set_size     = size_w[SIZE_W-1:0];
        merge_res.largest_size = largest_w[SIZE_W-1:0];
    end

    always_comb begin
        pa_raddr = cur_reg;
        pa_we    = 1'b0;
        pa_waddr = nxt_reg;
        pa_wdata = pa_rdata;
        sz_raddr = ra_reg;
        sz_we    = 1'b0;
        sz_waddr = top_node;
        sz_wdata = sum_size;
        unique case (state_reg)
            ST_SWEEP: begin
                pa_we    = 1'b1;
                pa_waddr = cnt_reg;
                pa_wdata = cnt_reg;
                sz_we    = 1'b1;
                sz_waddr = cnt_reg;
                sz_wdata = SW'(1);
            end
            ST_CHK_P, ST_CHK_G: begin
                pa_raddr = pa_rdata;
            end
            ST_WR: begin
                pa_we = 1'b1;
            end
            ST_SZ_B: begin
                sz_raddr = rb_reg;
            end
            ST_MERGE: begin
                pa_we    = distinct;
                pa_waddr = low_node;
                pa_wdata = top_node;
                sz_we    = distinct;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            cnt_reg      <= '0;
            clr_pend_reg <= 1'b0;
            phase_reg    <= 1'b0;
            largest_reg  <= SW'(1);
        end else begin
            unique case (state_reg)
                ST_SWEEP: begin
                    if (cnt_reg == LAST_NODE) begin
                        cnt_reg      <= '0;
                        largest_reg  <= SW'(1);
                        clr_pend_reg <= 1'b0;
                        if (clr_pend_reg) begin
                            res_reg.merged       <= 1'b0;
                            res_reg.result_root  <= '0;
                            res_reg.set_size     <= SIZE_W'(1);
                            res_reg.largest_size <= SIZE_W'(1);
                            state_reg            <= ST_RESULT;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + IW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        if (opcode == OP_CLEAR) begin
                            clr_pend_reg <= 1'b1;
                            state_reg    <= ST_SWEEP;
                        end else begin
                            a_reg     <= a_load;
                            b_reg     <= b_load;
                            state_reg <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE: begin
                    if ({1'b0, a_reg} >= NODES_W) begin
                        a_reg <= a_reg - NODES_W[RW-1:0];
                    end else if ({1'b0, b_reg} >= NODES_W) begin
                        b_reg <= b_reg - NODES_W[RW-1:0];
                    end else begin
                        cur_reg   <= a_reg[IW-1:0];
                        phase_reg <= 1'b0;
                        state_reg <= ST_RD_N;
                    end
                end
                ST_RD_N: begin
                    state_reg <= ST_CHK_P;
                end
                ST_CHK_P, ST_CHK_G: begin
                    if (found) begin
                        if (!phase_reg) begin
                            ra_reg    <= found_node;
                            cur_reg   <= b_reg[IW-1:0];
                            phase_reg <= 1'b1;
                            state_reg <= ST_RD_N;
                        end else begin
                            rb_reg    <= found_node;
                            state_reg <= ST_SZ_A;
                        end
                    end else if (state_reg == ST_CHK_P) begin
                        nxt_reg   <= pa_rdata;
                        state_reg <= ST_CHK_G;
                    end else begin
                        state_reg <= ST_WR;
                    end
                end
                ST_WR: begin
                    cur_reg   <= nxt_reg;
                    state_reg <= ST_RD_N;
                end
                ST_SZ_A: begin
                    state_reg <= ST_SZ_B;
                end
                ST_SZ_B: begin
                    sa_reg    <= sz_rdata;
                    state_reg <= ST_MERGE;
                end
                ST_MERGE: begin
                    res_reg     <= merge_res;
                    largest_reg <= largest_next;
                    state_reg   <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_no_self_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (pa_we && state_reg != ST_SWEEP) |-> (pa_waddr != pa_wdata))
        else $error("parent write would make a non-root point at itself");

    a_size_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        sz_we |-> (sz_wdata != '0))
        else $error("size table written with zero");

    a_largest_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(state_reg) != ST_SWEEP) |-> (largest_reg >= $past(largest_reg)))
        else $error("largest set size shrank outside a clear");

    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> s_ready)
        else $error("no return to idle after result transfer");

endmodule

// File: hdl/disjoint_set_union_engine_top.sv
// Disjoint-set union engine: path-halving root walks and union by size over a
// node table held in two synchronous RAMs. Top level of the block.
// Depends on dsu_pkg, dsu_ram and dsu_ctrl.
//
// Input channel s_*: s_opcode selects join (node_a with node_b) or clear.
// Result channel m_*: one transfer per input item carrying merged, the root of
// the joined set, its size and the largest set size since the last clear.
// Node indices are reduced modulo NODES; for a power-of-two NODES this is a
// mask, otherwise one subtraction per cycle.
// Join: each halving step that writes back reads the parent, grandparent and
// great-grandparent, then writes on the single parent RAM write port; the last
// step of each walk only finds the root.
// Clear: one table entry written per cycle.
// Items are handled one at a time: the next transfer in is taken only once the
// result of the last item has moved on and the engine is back in idle.
// After reset the same sweep runs with s_ready low and no result. The result
// sits in an output register: the engine takes the next item while it waits,
// and stalls only when a second result is finished before m_ready takes the
// first.
module disjoint_set_union_engine_top #(
    parameter int NODES = dsu_pkg::NODES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [dsu_pkg::NODE_W-1:0]   s_node_a,
    input  logic [dsu_pkg::NODE_W-1:0]   s_node_b,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_merged,
    output logic [dsu_pkg::NODE_W-1:0]   m_result_root,
    output logic [dsu_pkg::SIZE_W-1:0]   m_set_size,
    output logic [dsu_pkg::SIZE_W-1:0]   m_largest_size
);

    import dsu_pkg::*;

    localparam int IW = $clog2(NODES);

    logic          res_valid;
    logic          res_ready;
    dsu_res_t      res;
    logic          pa_we;
    logic [IW-1:0] pa_waddr;
    logic [IW-1:0] pa_wdata;
    logic [IW-1:0] pa_raddr;
    logic [IW-1:0] pa_rdata;
    logic          sz_we;
    logic [IW-1:0] sz_waddr;
    logic [IW:0]   sz_wdata;
    logic [IW-1:0] sz_raddr;
    logic [IW:0]   sz_rdata;

    logic          out_valid_reg;
    dsu_res_t      out_reg;

    dsu_ctrl #(.NODES(NODES)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .opcode    (s_opcode),
        .node_a    (s_node_a),
        .node_b    (s_node_b),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .pa_we     (pa_we),
        .pa_waddr  (pa_waddr),
        .pa_wdata  (pa_wdata),
        .pa_raddr  (pa_raddr),
        .pa_rdata  (pa_rdata),
        .sz_we     (sz_we),
        .sz_waddr  (sz_waddr),
        .sz_wdata  (sz_wdata),
        .sz_raddr  (sz_raddr),
        .sz_rdata  (sz_rdata)
    );

    dsu_ram #(.DEPTH(NODES), .WIDTH(IW)) u_parent_ram (
        .aclk  (aclk),
        .we    (pa_we),
        .waddr (pa_waddr),
        .wdata (pa_wdata),
        .raddr (pa_raddr),
        .rdata (pa_rdata)
    );

    dsu_ram #(.DEPTH(NODES), .WIDTH(IW + 1)) u_size_ram (
        .aclk  (aclk),
        .we    (sz_we),
        .waddr (sz_waddr),
        .wdata (sz_wdata),
        .raddr (sz_raddr),
        .rdata (sz_rdata)
    );

    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                out_valid_reg <= 1'b1;
                out_reg       <= res;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_merged       = out_reg.merged;
    assign m_result_root  = out_reg.result_root;
    assign m_set_size     = out_reg.set_size;
    assign m_largest_size = out_reg.largest_size;

endmodule

// File: bench/disjoint_set_union_engine_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the disjoint-set union engine: joins and clears, checked against
// a path-halving, union-by-size tracker. Depends on dsu_pkg and disjoint_set_union_engine_top.
module disjoint_set_union_engine_top_tb;
    import dsu_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEM_TARGET = 1750;
    localparam int HOLD_OFF    = 3000;
    localparam int HOLD_AFTER  = 400;

    class union_find_tracker;
        logic [NODE_W-1:0] parent_of [NODES_DEF];
        logic [SIZE_W-1:0] set_count [NODES_DEF];
        logic [SIZE_W-1:0] largest;
        dsu_res_t          join_outcomes [$];
        int                errors;

        function new();
            errors = 0;
            reset_sets();
        endfunction

        function void reset_sets();
            for (int n = 0; n < NODES_DEF; n++) begin
                parent_of[n] = NODE_W'(n);
                set_count[n] = 1;
            end
            largest = 1;
        endfunction

        function logic [NODE_W-1:0] walk_to_root(logic [NODE_W-1:0] n);
            int guard;
            guard = 0;
            while (parent_of[n] != n && guard < NODES_DEF) begin
                n = parent_of[n];
                parent_of[n] = parent_of[parent_of[n]];
                guard++;
            end
            return n;
        endfunction

        function void note_item(logic op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
            dsu_res_t          r;
            logic [NODE_W-1:0] ra, rb, top, low;
            r.merged      = 1'b0;
            r.result_root = '0;
            r.set_size    = 1;
            if (op == OP_CLEAR) begin
                reset_sets();
            end else begin
                ra = walk_to_root(NODE_W'(a % NODES_DEF));
                rb = walk_to_root(NODE_W'(b % NODES_DEF));
                if (ra == rb) begin
                    r.result_root = ra;
                end else begin
                    if (set_count[ra] > set_count[rb]) begin
                        top = ra;
                        low = rb;
                    end else begin
                        top = rb;
                        low = ra;
                    end
                    parent_of[low] = top;
                    set_count[top] = set_count[top] + set_count[low];
                    if (set_count[top] > largest) begin
                        largest = set_count[top];
                    end
                    r.merged      = 1'b1;
                    r.result_root = top;
                end
                r.set_size = set_count[r.result_root];
            end
            r.largest_size = largest;
            join_outcomes = {join_outcomes, r};
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic merged, logic [NODE_W-1:0] root,
                                   logic [SIZE_W-1:0] sz, logic [SIZE_W-1:0] lg);
            dsu_res_t r;
            if (join_outcomes.size() == 0) begin
                $error("result transfer with none outstanding");
                errors++;
                return;
            end
            r = join_outcomes.pop_front();
            compare_field("merged", 32'(r.merged), 32'(merged));
            compare_field("result_root", 32'(r.result_root), 32'(root));
            compare_field("set_size", 32'(r.set_size), 32'(sz));
            compare_field("largest_size", 32'(r.largest_size), 32'(lg));
        endfunction

        function int outstanding();
            return join_outcomes.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_opcode;
    logic [NODE_W-1:0] s_node_a;
    logic [NODE_W-1:0] s_node_b;
    logic              m_valid;
    logic              m_ready;
    logic              m_merged;
    logic [NODE_W-1:0] m_result_root;
    logic [SIZE_W-1:0] m_set_size;
    logic [SIZE_W-1:0] m_largest_size;

    union_find_tracker tracker = new();
    int  items_sent    = 0;
    int  results_taken = 0;
    int  cycle_count   = 0;
    bit  tx_steady     = 1'b0;
    bit  rx_steady     = 1'b0;

    disjoint_set_union_engine_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_node_a       (s_node_a),
        .s_node_b       (s_node_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_merged       (m_merged),
        .m_result_root  (m_result_root),
        .m_set_size     (m_set_size),
        .m_largest_size (m_largest_size)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            tracker.check_result(m_merged, m_result_root, m_set_size, m_largest_size);
            results_taken++;
        end
    end

    function automatic int idle_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [NODE_W-1:0] pick_node(int base, int width);
        return NODE_W'((base + $urandom_range(0, width - 1)) % NODES_DEF);
    endfunction

    task automatic send_item(input logic op, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b);
        int gap;
        gap = idle_gap(tx_steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_node_a <= a;
        s_node_b <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.note_item(op, a, b);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_join(input int a, input int b);
        send_item(OP_JOIN, NODE_W'(a), NODE_W'(b));
    endtask

    task automatic send_clear();
        send_item(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
    endtask

    task automatic directed_items();
        send_join(0, 0);
        send_join(0, 1023);
        send_join(1023, 0);
        send_join(5, 1023);
        send_join(1023, 6);
        send_join(10'h155, 10'h2AA);
        send_join(10'h2AA, 10'h155);
        // build a three-level tree by equal-size merges, then walk it from a leaf
        send_join(10, 11);
        send_join(12, 13);
        send_join(11, 13);
        send_join(14, 15);
        send_join(16, 17);
        send_join(15, 17);
        send_join(13, 17);
        send_join(10, 1023);
        send_join(12, 14);
        send_clear();
        send_join(1023, 1023);
        send_join(1, 2);
        send_clear();
    endtask

    task automatic random_phase();
        int base, width, count, stride, i;
        tx_steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0) send_clear();
        base = $urandom_range(0, NODES_DEF - 1);
        if ($urandom_range(0, 3) == 0) begin
            // pairwise doubling gives the deepest trees union by size allows
            width = 1 << $urandom_range(3, 7);
            for (stride = 1; stride < width; stride *= 2) begin
                for (i = 0; i + stride < width; i += 2 * stride) begin
                    if ($urandom_range(0, 1) == 0)
                        send_join((base + i) % NODES_DEF, (base + i + stride) % NODES_DEF);
                    else
                        send_join((base + i + stride) % NODES_DEF, (base + i) % NODES_DEF);
                end
            end
            count = $urandom_range(10, 40);
        end else begin
            case ($urandom_range(0, 3))
                0: width = 8;
                1: width = 32;
                2: width = 128;
                default: width = NODES_DEF;
            endcase
            count = $urandom_range(20, 120);
        end
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) == 0)
                send_clear();
            else
                send_item(OP_JOIN, pick_node(base, width), pick_node(base, width));
        end
    endtask

    initial begin
        int gap;
        bit held;
        m_ready = 1'b0;
        held    = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
            if (!held && results_taken >= HOLD_AFTER) begin
                // hold off long enough for the engine to fill and stall its input
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(negedge aclk);
            end else begin
                gap = idle_gap(rx_steady);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_opcode = OP_JOIN;
        s_node_a = '0;
        s_node_b = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        directed_items();
        while (items_sent < ITEM_TARGET) random_phase();
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
